### design/ikvhm_pkg.sv
// ----------------------------------------------------------------------------
// Integer key/value hash map package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package ikvhm_pkg;

    localparam int unsigned DefaultBuckets = 64;
    localparam int unsigned DefaultRecords = 256;

    localparam logic [2:0] KIND_LOOKUP = 3'd0;
    localparam logic [2:0] KIND_PUT    = 3'd1;
    localparam logic [2:0] KIND_INC    = 3'd2;
    localparam logic [2:0] KIND_REMOVE = 3'd3;
    localparam logic [2:0] KIND_TOTAL  = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_HASH,
        OP_RD_HEAD,
        OP_SET_CUR,
        OP_RD_REC,
        OP_ADVANCE,
        OP_LOOKUP_HIT,
        OP_MISS,
        OP_PUT_HIT,
        OP_INC_HIT,
        OP_RD_FREE,
        OP_INSERT,
        OP_FULL,
        OP_UNLINK,
        OP_FREE,
        OP_TOTAL,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] byte_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       cur_nil;
        logic       hit;
        logic       full;
        logic       clr_done;
    } dp_status_t;

endpackage

### design/ikvhm_dp.sv
// ----------------------------------------------------------------------------
// Hash map datapath
// Bucket and record memories, free list, running total and result registers.
// ----------------------------------------------------------------------------
module ikvhm_dp #(
    parameter int unsigned BUCKETS = ikvhm_pkg::DefaultBuckets,
    parameter int unsigned RECORDS = ikvhm_pkg::DefaultRecords
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ikvhm_pkg::dp_cmd_t   cmd,
    output ikvhm_pkg::dp_status_t status,
    input  logic [2:0]           in_kind,
    input  logic signed [31:0]   in_key,
    input  logic signed [31:0]   in_value,
    output logic                 out_found,
    output logic signed [31:0]   out_result_value,
    output logic                 out_status
);

    localparam int unsigned RW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned AW = $clog2(RECORDS);
    localparam int unsigned PW = $clog2(RECORDS + 1);
    localparam int unsigned SWEEP = (BUCKETS > RECORDS) ? BUCKETS : RECORDS;
    localparam int unsigned CW = (SWEEP > 1) ? $clog2(SWEEP) : 1;
    localparam logic [PW-1:0] NIL = PW'(RECORDS);

    logic [PW-1:0] bucket_mem [BUCKETS];
    logic [31:0]   rec_key_mem [RECORDS];
    logic [31:0]   rec_val_mem [RECORDS];
    logic [PW-1:0] rec_next_mem [RECORDS];

    logic [PW-1:0] bh_q_reg;
    logic [31:0]   rk_q_reg;
    logic [31:0]   rv_q_reg;
    logic [PW-1:0] rn_q_reg;

    logic [2:0]    kind_reg;
    logic [31:0]   key_reg;
    logic [31:0]   value_reg;
    logic [RW-1:0] rem_reg;
    logic [PW-1:0] cur_reg;
    logic [PW-1:0] prev_reg;
    logic [PW-1:0] free_head_reg;
    logic [PW-1:0] count_reg;
    logic [31:0]   total_reg;
    logic [CW-1:0] clr_reg;
    logic          found_reg;
    logic [31:0]   res_reg;
    logic          status_reg;
    logic          out_found_reg;
    logic [31:0]   out_res_reg;
    logic          out_status_reg;

    logic [RW-1:0] hash_next;
    logic [RW:0]   hash_t;
    logic [7:0]    hash_byte;
    logic          is_inc;
    logic [31:0]   ins_val;

    logic          bk_we;
    logic [RW-1:0] bk_waddr;
    logic [PW-1:0] bk_wdata;
    logic          kv_we;
    logic          key_we;
    logic [AW-1:0] kv_waddr;
    logic [31:0]   val_wdata;
    logic          nx_we;
    logic [AW-1:0] nx_waddr;
    logic [PW-1:0] nx_wdata;
    logic          rec_re;
    logic [AW-1:0] rec_raddr;

    always_comb begin
        hash_byte = key_reg[8 * (3 - cmd.byte_sel) +: 8];
        hash_t    = '0;
        hash_next = rem_reg;
        for (int i = 7; i >= 0; i--) begin
            hash_t = {hash_next, hash_byte[i]};
            if (hash_t >= (RW + 1)'(BUCKETS)) begin
                hash_t = hash_t - (RW + 1)'(BUCKETS);
            end
            hash_next = hash_t[RW-1:0];
        end
    end

    assign is_inc  = (kind_reg == ikvhm_pkg::KIND_INC);
    assign ins_val = is_inc ? 32'd1 : value_reg;

    always_comb begin
        bk_we     = 1'b0;
        bk_waddr  = rem_reg;
        bk_wdata  = free_head_reg;
        kv_we     = 1'b0;
        key_we    = 1'b0;
        kv_waddr  = cur_reg[AW-1:0];
        val_wdata = value_reg;
        nx_we     = 1'b0;
        nx_waddr  = free_head_reg[AW-1:0];
        nx_wdata  = bh_q_reg;
        rec_re    = 1'b0;
        rec_raddr = cur_reg[AW-1:0];
        case (cmd.op)
            ikvhm_pkg::OP_CLEAR: begin
                bk_we    = ({1'b0, clr_reg} < (CW + 1)'(BUCKETS));
                bk_waddr = clr_reg[RW-1:0];
                bk_wdata = NIL;
                nx_we    = ({1'b0, clr_reg} < (CW + 1)'(RECORDS));
                nx_waddr = clr_reg[AW-1:0];
                nx_wdata = PW'(clr_reg) + PW'(1);
            end
            ikvhm_pkg::OP_RD_REC: begin
                rec_re = 1'b1;
            end
            ikvhm_pkg::OP_RD_FREE: begin
                rec_re    = 1'b1;
                rec_raddr = free_head_reg[AW-1:0];
            end
            ikvhm_pkg::OP_PUT_HIT: begin
                kv_we = 1'b1;
            end
            ikvhm_pkg::OP_INC_HIT: begin
                kv_we     = 1'b1;
                val_wdata = rv_q_reg + 32'd1;
            end
            ikvhm_pkg::OP_INSERT: begin
                kv_we     = 1'b1;
                key_we    = 1'b1;
                kv_waddr  = free_head_reg[AW-1:0];
                val_wdata = ins_val;
                nx_we     = 1'b1;
                bk_we     = 1'b1;
            end
            ikvhm_pkg::OP_UNLINK: begin
                if (prev_reg == NIL) begin
                    bk_we    = 1'b1;
                    bk_wdata = rn_q_reg;
                end else begin
                    nx_we    = 1'b1;
                    nx_waddr = prev_reg[AW-1:0];
                    nx_wdata = rn_q_reg;
                end
            end
            ikvhm_pkg::OP_FREE: begin
                nx_we    = 1'b1;
                nx_waddr = cur_reg[AW-1:0];
                nx_wdata = free_head_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (bk_we) begin
            bucket_mem[bk_waddr] <= bk_wdata;
        end
        if (cmd.op == ikvhm_pkg::OP_RD_HEAD) begin
            bh_q_reg <= bucket_mem[rem_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (kv_we) begin
            rec_val_mem[kv_waddr] <= val_wdata;
        end
        if (key_we) begin
            rec_key_mem[kv_waddr] <= key_reg;
        end
        if (nx_we) begin
            rec_next_mem[nx_waddr] <= nx_wdata;
        end
        if (rec_re) begin
            rk_q_reg <= rec_key_mem[rec_raddr];
            rv_q_reg <= rec_val_mem[rec_raddr];
            rn_q_reg <= rec_next_mem[rec_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            ikvhm_pkg::OP_LOAD: begin
                kind_reg   <= in_kind;
                key_reg    <= in_key;
                value_reg  <= in_value;
                rem_reg    <= '0;
                found_reg  <= 1'b0;
                res_reg    <= '0;
                status_reg <= 1'b0;
            end
            ikvhm_pkg::OP_HASH:       rem_reg <= hash_next;
            ikvhm_pkg::OP_SET_CUR: begin
                cur_reg  <= bh_q_reg;
                prev_reg <= NIL;
            end
            ikvhm_pkg::OP_ADVANCE: begin
                prev_reg <= cur_reg;
                cur_reg  <= rn_q_reg;
            end
            ikvhm_pkg::OP_LOOKUP_HIT: begin
                found_reg <= 1'b1;
                res_reg   <= rv_q_reg;
            end
            ikvhm_pkg::OP_MISS:       res_reg <= '1;
            ikvhm_pkg::OP_PUT_HIT:    found_reg <= 1'b1;
            ikvhm_pkg::OP_INC_HIT: begin
                found_reg <= 1'b1;
                res_reg   <= rv_q_reg + 32'd1;
            end
            ikvhm_pkg::OP_INSERT:     res_reg <= is_inc ? 32'd1 : 32'd0;
            ikvhm_pkg::OP_FULL:       status_reg <= 1'b1;
            ikvhm_pkg::OP_UNLINK:     found_reg <= 1'b1;
            ikvhm_pkg::OP_TOTAL:      res_reg <= total_reg;
            ikvhm_pkg::OP_PUBLISH: begin
                out_found_reg  <= found_reg;
                out_res_reg    <= res_reg;
                out_status_reg <= status_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            clr_reg       <= '0;
        end else begin
            case (cmd.op)
                ikvhm_pkg::OP_CLEAR:   clr_reg <= clr_reg + CW'(1);
                ikvhm_pkg::OP_PUT_HIT: total_reg <= total_reg - rv_q_reg + value_reg;
                ikvhm_pkg::OP_INC_HIT: total_reg <= total_reg + 32'd1;
                ikvhm_pkg::OP_INSERT: begin
                    free_head_reg <= rn_q_reg;
                    count_reg     <= count_reg + PW'(1);
                    total_reg     <= total_reg + ins_val;
                end
                ikvhm_pkg::OP_UNLINK: begin
                    total_reg <= total_reg - rv_q_reg;
                    if (count_reg != '0) begin
                        count_reg <= count_reg - PW'(1);
                    end
                end
                ikvhm_pkg::OP_FREE:    free_head_reg <= cur_reg;
                default: begin
                end
            endcase
        end
    end

    assign status.kind     = kind_reg;
    assign status.cur_nil  = (cur_reg == NIL);
    assign status.hit      = (rk_q_reg == key_reg);
    assign status.full     = (count_reg >= NIL) || (free_head_reg == NIL);
    assign status.clr_done = (clr_reg == CW'(SWEEP - 1));

    assign out_found        = out_found_reg;
    assign out_result_value = out_res_reg;
    assign out_status       = out_status_reg;

endmodule

### design/ikvhm_ctrl.sv
// ----------------------------------------------------------------------------
// Hash map controller
// Sequences the clearing pass, key hashing, chain walk and updates.
// ----------------------------------------------------------------------------
module ikvhm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ikvhm_pkg::dp_cmd_t    cmd,
    input  ikvhm_pkg::dp_status_t status
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_HEAD,
        ST_SETCUR,
        ST_WALK,
        ST_CHECK,
        ST_ALLOC,
        ST_FREE,
        ST_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        cmd.op       = ikvhm_pkg::OP_NONE;
        cmd.byte_sel = cnt_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: begin
                cmd.op = ikvhm_pkg::OP_CLEAR;
                if (status.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = ikvhm_pkg::OP_LOAD;
                    cnt_next   = '0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                if (status.kind == ikvhm_pkg::KIND_TOTAL) begin
                    cmd.op     = ikvhm_pkg::OP_TOTAL;
                    state_next = ST_DONE;
                end else if (status.kind > ikvhm_pkg::KIND_TOTAL) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.op   = ikvhm_pkg::OP_HASH;
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) begin
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_HEAD: begin
                cmd.op     = ikvhm_pkg::OP_RD_HEAD;
                state_next = ST_SETCUR;
            end
            ST_SETCUR: begin
                cmd.op     = ikvhm_pkg::OP_SET_CUR;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (!status.cur_nil) begin
                    cmd.op     = ikvhm_pkg::OP_RD_REC;
                    state_next = ST_CHECK;
                end else begin
                    state_next = ST_DONE;
                    case (status.kind)
                        ikvhm_pkg::KIND_LOOKUP: cmd.op = ikvhm_pkg::OP_MISS;
                        ikvhm_pkg::KIND_PUT, ikvhm_pkg::KIND_INC: begin
                            if (status.full) begin
                                cmd.op = ikvhm_pkg::OP_FULL;
                            end else begin
                                cmd.op     = ikvhm_pkg::OP_RD_FREE;
                                state_next = ST_ALLOC;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                if (status.hit) begin
                    state_next = ST_DONE;
                    case (status.kind)
                        ikvhm_pkg::KIND_LOOKUP: cmd.op = ikvhm_pkg::OP_LOOKUP_HIT;
                        ikvhm_pkg::KIND_PUT:    cmd.op = ikvhm_pkg::OP_PUT_HIT;
                        ikvhm_pkg::KIND_INC:    cmd.op = ikvhm_pkg::OP_INC_HIT;
                        default: begin
                            cmd.op     = ikvhm_pkg::OP_UNLINK;
                            state_next = ST_FREE;
                        end
                    endcase
                end else begin
                    cmd.op     = ikvhm_pkg::OP_ADVANCE;
                    state_next = ST_WALK;
                end
            end
            ST_ALLOC: begin
                cmd.op     = ikvhm_pkg::OP_INSERT;
                state_next = ST_DONE;
            end
            ST_FREE: begin
                cmd.op     = ikvhm_pkg::OP_FREE;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = ikvhm_pkg::OP_PUBLISH;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### design/int_key_value_hash_map.sv
// ----------------------------------------------------------------------------
// Integer key/value hash map
// Chained hash table over a fixed record pool with a free list.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over max(BUCKETS, RECORDS) addresses
// and takes no request until it ends. Each request is handled on its own: the
// block takes it, reduces the key modulo BUCKETS a byte at a time, fetches the
// bucket head, reads each record visited on the chain through the single record
// memory port, finishes the update and presents the result. A total or an
// undefined kind skips the hashing and the chain walk. A result waits in the
// output register while the next request is taken.
module int_key_value_hash_map #(
    parameter int unsigned BUCKETS = ikvhm_pkg::DefaultBuckets,
    parameter int unsigned RECORDS = ikvhm_pkg::DefaultRecords
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_kind,
    input  logic signed [31:0] s_key,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_found,
    output logic signed [31:0] m_result_value,
    output logic               m_status
);

    ikvhm_pkg::dp_cmd_t    cmd;
    ikvhm_pkg::dp_status_t status;

    ikvhm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    ikvhm_dp #(
        .BUCKETS (BUCKETS),
        .RECORDS (RECORDS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .in_kind          (s_kind),
        .in_key           (s_key),
        .in_value         (s_value),
        .out_found        (m_found),
        .out_result_value (m_result_value),
        .out_status       (m_status)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Request taken while another is in progress.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> !m_found)
        else $error("Refused request reports a present key.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value))
        else $error("Pending result changed before it was taken.");

endmodule

### tb/int_key_value_hash_map_test.sv
// ----------------------------------------------------------------------------
// Integer key/value hash map testbench
// Drives lookup, put, increment, remove, total and undefined-kind requests, with random
// handshake gaps for most of the run, and compares each result with a behavioral hash map model.
// ----------------------------------------------------------------------------
module int_key_value_hash_map_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NB = 64;
    localparam int unsigned NR = 256;
    localparam int unsigned NILR = NR;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic        found;
        logic [31:0] value;
        logic        status;
    } map_reply_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_kind = '0;
    logic signed [31:0] s_key = '0;
    logic signed [31:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_found;
    logic signed [31:0] m_result_value;
    logic               m_status;

    int unsigned m_head [NB];
    logic [31:0] m_rkey [NR];
    logic [31:0] m_rval [NR];
    int unsigned m_next [NR];
    int unsigned m_free;
    int unsigned m_count;
    logic [31:0] m_total;

    map_reply_t  pending_replies [$];
    int          error_count = 0;
    int          reply_count = 0;
    int          request_count = 0;
    longint      cycle_count = 0;
    bit          gaps_on = 1'b1;
    logic [31:0] key_pool [16];

    int_key_value_hash_map DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_kind(s_kind), .s_key(s_key), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_found(m_found), .m_result_value(m_result_value), .m_status(m_status)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("int_key_value_hash_map: mismatch");
            $finish;
        end
    end

    task automatic report_error(input string what);
        error_count++;
        $display("error at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic void map_clear();
        for (int i = 0; i < NB; i++) m_head[i] = NILR;
        for (int i = 0; i < NR; i++) begin
            m_rkey[i] = '0;
            m_rval[i] = '0;
            m_next[i] = i + 1;
        end
        m_free = 0;
        m_count = 0;
        m_total = '0;
    endfunction

    function automatic int unsigned map_find(input logic [31:0] k,
                                             output int unsigned prev);
        int unsigned cur;
        int unsigned steps;
        cur = m_head[k % NB];
        prev = NILR;
        steps = 0;
        while (cur < NILR && steps < NR) begin
            if (m_rkey[cur] == k) return cur;
            prev = cur;
            cur = m_next[cur];
            steps++;
        end
        prev = NILR;
        return NILR;
    endfunction

    function automatic bit map_insert(input logic [31:0] k, input logic [31:0] v);
        int unsigned r;
        r = m_free;
        if (r >= NILR || m_count >= NR) return 1'b0;
        m_free = m_next[r];
        m_rkey[r] = k;
        m_rval[r] = v;
        m_next[r] = m_head[k % NB];
        m_head[k % NB] = r;
        m_count++;
        m_total = m_total + v;
        return 1'b1;
    endfunction

    function automatic map_reply_t map_apply(input logic [2:0] kind,
                                             input logic [31:0] k,
                                             input logic [31:0] v);
        map_reply_t  rep;
        int unsigned r;
        int unsigned prev;
        rep = '0;
        case (kind)
            ikvhm_pkg::KIND_LOOKUP: begin
                r = map_find(k, prev);
                if (r < NILR) begin
                    rep.found = 1'b1;
                    rep.value = m_rval[r];
                end else begin
                    rep.value = 32'hFFFF_FFFF;
                end
            end
            ikvhm_pkg::KIND_PUT: begin
                r = map_find(k, prev);
                if (r < NILR) begin
                    rep.found = 1'b1;
                    m_total = m_total - m_rval[r] + v;
                    m_rval[r] = v;
                end else if (!map_insert(k, v)) begin
                    rep.status = 1'b1;
                end
            end
            ikvhm_pkg::KIND_INC: begin
                r = map_find(k, prev);
                if (r < NILR) begin
                    rep.found = 1'b1;
                    m_rval[r] = m_rval[r] + 1;
                    m_total = m_total + 1;
                    rep.value = m_rval[r];
                end else if (!map_insert(k, 32'd1)) begin
                    rep.status = 1'b1;
                end else begin
                    rep.value = 32'd1;
                end
            end
            ikvhm_pkg::KIND_REMOVE: begin
                r = map_find(k, prev);
                if (r < NILR) begin
                    rep.found = 1'b1;
                    if (prev < NILR) m_next[prev] = m_next[r];
                    else m_head[k % NB] = m_next[r];
                    m_total = m_total - m_rval[r];
                    m_next[r] = m_free;
                    m_free = r;
                    if (m_count > 0) m_count--;
                end
            end
            ikvhm_pkg::KIND_TOTAL: rep.value = m_total;
            default: ;
        endcase
        return rep;
    endfunction

    task automatic send_request(input logic [2:0] kind, input logic [31:0] k,
                                input logic [31:0] v);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_kind <= kind;
        s_key <= k;
        s_value <= v;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_replies.push_back(map_apply(kind, k, v));
        request_count++;
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (!gaps_on || $urandom_range(0, 3) != 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        map_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            reply_count++;
            if (pending_replies.size() == 0) begin
                report_error("result with no request outstanding");
            end else begin
                want = pending_replies.pop_front();
                if (m_found !== want.found || m_result_value !== want.value
                        || m_status !== want.status)
                    report_error($sformatf("got %b/%h/%b want %b/%h/%b",
                        m_found, m_result_value, m_status,
                        want.found, want.value, want.status));
            end
        end
    end

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 15)];
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        send_request(ikvhm_pkg::KIND_LOOKUP, 32'h8000_0000, 32'd0);
        send_request(ikvhm_pkg::KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(ikvhm_pkg::KIND_PUT, 32'hFFFF_FFC0, 32'hFFFF_FFFF);
        send_request(ikvhm_pkg::KIND_PUT, 32'h0000_0000, 32'h8000_0000);
        send_request(ikvhm_pkg::KIND_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(ikvhm_pkg::KIND_TOTAL, 32'd0, 32'd0);
        send_request(ikvhm_pkg::KIND_INC, 32'h8000_0000, 32'd0);
        send_request(ikvhm_pkg::KIND_INC, 32'hFFFF_FFC0, 32'd0);
        send_request(ikvhm_pkg::KIND_INC, 32'h0000_0040, 32'd0);
        send_request(ikvhm_pkg::KIND_PUT, 32'h0000_0040, 32'h1234_5678);
        send_request(ikvhm_pkg::KIND_REMOVE, 32'h0000_0000, 32'd0);
        send_request(ikvhm_pkg::KIND_REMOVE, 32'h0000_0000, 32'd0);
        send_request(ikvhm_pkg::KIND_REMOVE, 32'h0000_0040, 32'd0);
        send_request(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(3'd6, 32'd1, 32'd1);
        send_request(3'd7, 32'd2, 32'd2);
        send_request(ikvhm_pkg::KIND_TOTAL, 32'hFFFF_FFFF, 32'd0);
        send_request(ikvhm_pkg::KIND_LOOKUP, 32'h7FFF_FFFF, 32'd0);
    endtask

    task automatic test_fill_pool();
        for (int i = 0; i < NR + 4; i++)
            send_request(ikvhm_pkg::KIND_PUT, (i * NB) ^ 32'h5A00_0000, $urandom());
        send_request(ikvhm_pkg::KIND_INC, 32'h7FFF_FFFF, 32'd0);
        send_request(ikvhm_pkg::KIND_PUT, 32'h7FFF_FFFF, 32'd3);
        send_request(ikvhm_pkg::KIND_TOTAL, 32'd0, 32'd0);
        for (int i = 0; i < NR; i++)
            send_request(ikvhm_pkg::KIND_REMOVE, (i * NB) ^ 32'h5A00_0000, 32'd0);
        send_request(ikvhm_pkg::KIND_TOTAL, 32'd0, 32'd0);
    endtask

    task automatic test_random(input int n);
        logic [2:0] kind;
        for (int i = 0; i < 16; i++)
            key_pool[i] = (i < 8) ? (($urandom() << 6) | 32'd5) : $urandom();
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4:     kind = ikvhm_pkg::KIND_LOOKUP;
                5, 6, 7, 8, 9:     kind = ikvhm_pkg::KIND_PUT;
                10, 11, 12, 13:    kind = ikvhm_pkg::KIND_INC;
                14, 15, 16:        kind = ikvhm_pkg::KIND_REMOVE;
                17, 18:            kind = ikvhm_pkg::KIND_TOTAL;
                default:           kind = 3'($urandom_range(5, 7));
            endcase
            send_request(kind, pick_key(), pick_value());
        end
    endtask

    initial begin
        map_clear();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_fill_pool();
        test_random(200);
        gaps_on = 1'b0;
        test_random(60);
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("sent %0d requests and checked %0d results, including a full pool,",
                 request_count, reply_count);
        $display("chained collisions, wrap-around and undefined kinds");
        if (error_count == 0 && pending_replies.size() == 0) begin
            $display("int_key_value_hash_map: match");
        end else begin
            $display("int_key_value_hash_map: mismatch");
        end
        $finish;
    end
endmodule

### sim.f
design/ikvhm_pkg.sv
design/ikvhm_dp.sv
design/ikvhm_ctrl.sv
design/int_key_value_hash_map.sv
tb/int_key_value_hash_map_test.sv
